// ----- rtl/dsem_pkg.sv -----
// ----------------------------------------------------------------------------
// dsem_pkg: shared constants and tables
// Calendar constants and month tables for the date text to epoch converter.
// ----------------------------------------------------------------------------
package dsem_pkg;

  localparam int unsigned FieldW   = 17;
  localparam int unsigned YearW    = 15;
  localparam int unsigned AccW     = 25;
  localparam int unsigned MillisW  = 51;
  localparam int unsigned MulAW    = 26;
  localparam int unsigned MulBW    = 28;

  localparam logic [FieldW-1:0] ValueMax = 17'd99999;
  localparam logic [FieldW-1:0] YearMax  = 17'd32767;

  // n / 100 == (n * 5243) >> 19 for every n below 43699
  localparam logic signed [MulBW-1:0] Recip100   = 28'sd5243;
  localparam int unsigned             Recip100Sh = 19;
  localparam logic signed [MulBW-1:0] DaysPerYr  = 28'sd365;
  localparam logic signed [MulBW-1:0] MsPerDay   = 28'sd86400000;

  // Day count from 0000-03-01 to 1970-01-01
  localparam logic [AccW-1:0] EpochDays = 25'd719468;

  // Day of year at the first of each month, counted from March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                              n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:           n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                      n = 5'd31;
      default:                           n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/date_string_to_epoch_millis.sv -----
// ----------------------------------------------------------------------------
// date_string_to_epoch_millis: date text to epoch milliseconds
// Parses year, month and day from a byte stream, validates the calendar
// date and computes milliseconds since 1970-01-01 with one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | dir | data                          | side band
//  --------+-----+-------------------------------+-------------------------
//  in_     | in  | tdata[7:0]  char_code         | tlast = last_char
//  out_    | out | tdata[50:0] date_millis (s)   | tuser[0] = invalid
//
//  A byte that is not the last keeps the parser idle, so in_tready stays high.
//  The last byte starts a seven-step sequence through the shared multiplier
//  and adder (check, y/100, leap, ya/100, ya*365, sum, days*ms); in_tready
//  is low during the sequence.
//  A result waiting on out_tready holds the final step until the output
//  register frees.
//  rst_n is synchronous, active low; it clears the parser and output valid.
// ----------------------------------------------------------------------------
module date_string_to_epoch_millis (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [50:0] date_millis, [55:51] zero
  output logic        out_tuser   // [0] invalid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_Y,
    ST_LEAP,
    ST_DIV_YA,
    ST_MUL365,
    ST_SUM,
    ST_MS
  } state_t;

  localparam int unsigned FW = dsem_pkg::FieldW;
  localparam int unsigned YW = dsem_pkg::YearW;
  localparam int unsigned AW = dsem_pkg::AccW;
  localparam int unsigned MW = dsem_pkg::MillisW;

  state_t state_r, state_nxt;

  logic [1:0]          fields_done_r, fields_done_nxt;
  logic [FW-1:0]       digit_r, digit_nxt;
  logic [FW-1:0]       yf_r, yf_nxt;
  logic [FW-1:0]       mf_r, mf_nxt;
  logic [FW-1:0]       df_r, df_nxt;

  logic                bad_r, bad_nxt;
  logic [YW-1:0]       yr_r, yr_nxt;
  logic [3:0]          mo_r, mo_nxt;
  logic [4:0]          dy_r, dy_nxt;
  logic [8:0]          q_r, q_nxt;
  logic [8:0]          qa_r, qa_nxt;
  logic [YW-1:0]       ya_r, ya_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [MW-1:0]       millis_r, millis_nxt;
  logic                inv_r, inv_nxt;

  // shared multiplier
  logic signed [dsem_pkg::MulAW-1:0] mul_a;
  logic signed [dsem_pkg::MulBW-1:0] mul_b;
  logic signed [53:0]                mul_p;

  assign mul_p = mul_a * mul_b;

  // parser scratch
  logic          in_acc;
  logic          is_digit;
  logic [20:0]   times10;
  logic [1:0]    fd;
  logic [FW-1:0] dv;

  // calendar scratch
  logic [FW-1:0] ymap;
  logic [15:0]   hund;
  logic [15:0]   rem100;
  logic          leap;
  logic [4:0]    mlen;
  logic [3:0]    mp;
  logic [9:0]    doy;
  logic [AW-1:0] sum;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, millis_r};
  assign out_tuser  = inv_r;

  always_comb begin
    state_nxt       = state_r;
    fields_done_nxt = fields_done_r;
    digit_nxt       = digit_r;
    yf_nxt          = yf_r;
    mf_nxt          = mf_r;
    df_nxt          = df_r;
    bad_nxt         = bad_r;
    yr_nxt          = yr_r;
    mo_nxt          = mo_r;
    dy_nxt          = dy_r;
    q_nxt           = q_r;
    qa_nxt          = qa_r;
    ya_nxt          = ya_r;
    acc_nxt         = acc_r;
    millis_nxt      = millis_r;
    inv_nxt         = inv_r;
    out_valid_nxt   = out_valid_r && !out_tready;

    mul_a = '0;
    mul_b = '0;

    is_digit = in_tdata inside {[8'h30:8'h39]};
    times10  = {1'b0, digit_r, 3'b0} + {3'b0, digit_r, 1'b0} + {17'b0, in_tdata[3:0]};
    fd       = fields_done_r;
    dv       = digit_r;

    ymap = (yf_r < 17'd100) ? (yf_r + ((yf_r < 17'd70) ? 17'd2000 : 17'd1900)) : yf_r;

    hund   = 16'({q_r, 6'b0}) + 16'({q_r, 5'b0}) + 16'({q_r, 2'b0});
    rem100 = {1'b0, yr_r} - hund;
    leap   = (yr_r[1:0] == 2'd0) && ((rem100 != 16'd0) || (q_r[1:0] == 2'd0));
    mlen   = dsem_pkg::month_days(mo_r, leap);

    mp   = (mo_r > 4'd2) ? (mo_r - 4'd3) : (mo_r + 4'd9);
    doy  = {1'b0, dsem_pkg::month_start(mp)} + {5'b0, dy_r} - 10'd1;
    sum  = AW'(acc_r) + {10'b0, ya_r >> 2} - {16'b0, qa_r} + {18'b0, qa_r[8:2]}
         + {15'b0, doy} - dsem_pkg::EpochDays;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (fd != 2'd3) begin
            if (is_digit) begin
              dv = (times10 > 21'(dsem_pkg::ValueMax)) ? dsem_pkg::ValueMax : times10[FW-1:0];
            end else begin
              case (fd)
                2'd0:    yf_nxt = dv;
                2'd1:    mf_nxt = dv;
                default: df_nxt = dv;
              endcase
              fd = fd + 2'd1;
              dv = '0;
            end
          end
          if (in_tlast) begin
            // close the open field at end of string
            if (fd != 2'd3) begin
              case (fd)
                2'd0:    yf_nxt = dv;
                2'd1:    mf_nxt = dv;
                default: df_nxt = dv;
              endcase
              fd = fd + 2'd1;
            end
            bad_nxt         = (fd != 2'd3);
            fields_done_nxt = '0;
            digit_nxt       = '0;
            state_nxt       = ST_CHECK;
          end else begin
            fields_done_nxt = fd;
            digit_nxt       = dv;
          end
        end
      end
      ST_CHECK: begin
        if ((ymap > dsem_pkg::YearMax) || (mf_r < 17'd1) || (mf_r > 17'd12) ||
            (df_r < 17'd1) || (df_r > 17'd31)) begin
          bad_nxt = 1'b1;
        end
        yr_nxt    = ymap[YW-1:0];
        mo_nxt    = mf_r[3:0];
        dy_nxt    = df_r[4:0];
        state_nxt = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        mul_a     = $signed({11'b0, yr_r});
        mul_b     = dsem_pkg::Recip100;
        q_nxt     = mul_p[dsem_pkg::Recip100Sh +: 9];
        state_nxt = ST_LEAP;
      end
      ST_LEAP: begin
        if (dy_r > mlen) begin
          bad_nxt = 1'b1;
        end
        // the year begins in March
        ya_nxt    = (mo_r <= 4'd2) ? (yr_r - 15'd1) : yr_r;
        state_nxt = ST_DIV_YA;
      end
      ST_DIV_YA: begin
        mul_a     = $signed({11'b0, ya_r});
        mul_b     = dsem_pkg::Recip100;
        qa_nxt    = mul_p[dsem_pkg::Recip100Sh +: 9];
        state_nxt = ST_MUL365;
      end
      ST_MUL365: begin
        mul_a     = $signed({11'b0, ya_r});
        mul_b     = dsem_pkg::DaysPerYr;
        acc_nxt   = mul_p[AW-1:0];
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        acc_nxt   = $signed(sum);
        state_nxt = ST_MS;
      end
      ST_MS: begin
        mul_a = {acc_r[AW-1], acc_r};
        mul_b = dsem_pkg::MsPerDay;
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          millis_nxt    = bad_r ? '0 : mul_p[MW-1:0];
          inv_nxt       = bad_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fields_done_r <= '0;
      digit_r       <= '0;
      yf_r          <= '0;
      mf_r          <= '0;
      df_r          <= '0;
      bad_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fields_done_r <= fields_done_nxt;
      digit_r       <= digit_nxt;
      yf_r          <= yf_nxt;
      mf_r          <= mf_nxt;
      df_r          <= df_nxt;
      bad_r         <= bad_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    yr_r     <= yr_nxt;
    mo_r     <= mo_nxt;
    dy_r     <= dy_nxt;
    q_r      <= q_nxt;
    qa_r     <= qa_nxt;
    ya_r     <= ya_nxt;
    acc_r    <= acc_nxt;
    millis_r <= millis_nxt;
    inv_r    <= inv_nxt;
  end

  a_rose_after_ms: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_MS)
    else $error("result valid raised outside the final step");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && inv_r |-> millis_r == '0)
    else $error("invalid result carries nonzero millis");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready && state_r == ST_CHECK)
    else $error("last byte did not start the sequence");

  a_parser_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> fields_done_r == 2'd0 && digit_r == '0)
    else $error("parser state not cleared at end of string");

endmodule
